@@ hw/rtl/mvna_pkg.sv @@
// ----------------------------------------------------------------------------
// Mesh vertex normal accumulator package
// Shared widths, command and result words, state types.
// ----------------------------------------------------------------------------
package mvna_pkg;

  localparam int DEF_VERTEX_DEPTH = 4096;
  localparam int QUEUE_DEPTH      = 2;

  localparam int IDX_W   = 12;
  localparam int POS_W   = 32;
  localparam int NRM_W   = 16;
  localparam int ACC_W   = 24;
  localparam int EDGE_W  = 31;   // edge component after range reduction
  localparam int VEC_W   = 62;   // unit vector engine input component
  localparam int MAG_W   = 30;   // magnitude inside the normalizing window
  localparam int ROOT_W  = 31;
  localparam int FRAC_W  = 14;   // Q2.14 fraction bits
  localparam int NUM_W   = 45;   // rounded dividend

  localparam int SHRINK_STEPS = 3;
  localparam int MUL_STEPS    = 6;
  localparam int SQ_STEPS     = 4;
  localparam int SQRT_STEPS   = 31;
  localparam int DIV_STEPS    = 16;
  localparam int CORNERS      = 3;

  typedef enum logic [1:0] {
    ACT_WRITE    = 2'd0,
    ACT_TRIANGLE = 2'd1,
    ACT_READ     = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_TRIANGLE,
    CMD_READ,
    CMD_READ_ZERO
  } cmd_op_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [ACC_W-1:0] z;
  } acc_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } vec3_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] x;
    logic signed [NRM_W-1:0] y;
    logic signed [NRM_W-1:0] z;
  } nrm3_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [IDX_W-1:0] idx;
    pos_t             pos;
    logic [IDX_W-1:0] ca;
    logic [IDX_W-1:0] cb;
    logic [IDX_W-1:0] cc;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    nrm3_t            nrm;
  } result_t;

  localparam int CMD_W    = $bits(cmd_t);
  localparam int RESULT_W = $bits(result_t);

  typedef struct packed {
    logic cmd_pop;
    logic clearing;
  } back_stat_t;

  typedef struct packed {
    logic  start;
    vec3_t vec;
  } unit_req_t;

  typedef struct packed {
    logic  done;
    nrm3_t nrm;
  } unit_rsp_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_PA,
    B_PB,
    B_PC,
    B_EDGE,
    B_MUL,
    B_USTART,
    B_UNIT_TRI,
    B_ACC_RD,
    B_ACC_WR,
    B_RD,
    B_UNIT_RD,
    B_OUT
  } back_state_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_NORM,
    U_SQ,
    U_SQRT,
    U_DSET,
    U_DIV,
    U_FIN
  } unit_state_t;

endpackage

@@ hw/rtl/mvna_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mvna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/mvna_queue.sv @@
// ----------------------------------------------------------------------------
// Small word queue
// Register-based first-in first-out buffer with push/full and pop/empty.
// ----------------------------------------------------------------------------
module mvna_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] slot [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign full    = (count == (PW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign rdata   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= wdata;
    end
  end

endmodule

@@ hw/rtl/mvna_front.sv @@
// ----------------------------------------------------------------------------
// Front end
// Accepts input words, range-checks indices, drops no-op words and queues
// commands for the back end.
// ----------------------------------------------------------------------------
module mvna_front #(
  parameter int VERTEX_DEPTH = 4096
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        action,
  input  logic [mvna_pkg::IDX_W-1:0]        vertex_index,
  input  logic signed [mvna_pkg::POS_W-1:0] position_x,
  input  logic signed [mvna_pkg::POS_W-1:0] position_y,
  input  logic signed [mvna_pkg::POS_W-1:0] position_z,
  input  logic [mvna_pkg::IDX_W-1:0]        corner_a,
  input  logic [mvna_pkg::IDX_W-1:0]        corner_b,
  input  logic [mvna_pkg::IDX_W-1:0]        corner_c,
  input  mvna_pkg::back_stat_t              stat,
  output logic                              cmd_valid,
  output mvna_pkg::cmd_t                    cmd
);

  import mvna_pkg::*;

  function automatic logic in_range(logic [IDX_W-1:0] i);
    return 32'(i) < 32'(VERTEX_DEPTH);
  endfunction

  cmd_t             new_cmd;
  logic             keep;
  logic             q_full;
  logic             q_empty;
  logic [CMD_W-1:0] q_rdata;

  always_comb begin
    new_cmd.idx   = vertex_index;
    new_cmd.pos.x = position_x;
    new_cmd.pos.y = position_y;
    new_cmd.pos.z = position_z;
    new_cmd.ca    = corner_a;
    new_cmd.cb    = corner_b;
    new_cmd.cc    = corner_c;
    new_cmd.op    = CMD_WRITE;
    keep          = 1'b0;
    case (action_t'(action))
      ACT_WRITE: begin
        new_cmd.op = CMD_WRITE;
        keep       = in_range(vertex_index);
      end
      ACT_TRIANGLE: begin
        new_cmd.op = CMD_TRIANGLE;
        keep       = in_range(corner_a) && in_range(corner_b) && in_range(corner_c);
      end
      ACT_READ: begin
        // out of range reads still answer, with a zero normal
        new_cmd.op = in_range(vertex_index) ? CMD_READ : CMD_READ_ZERO;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full = stat.clearing || q_full;

  mvna_queue #(
    .WIDTH(CMD_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push && !full && keep),
    .wdata(new_cmd),
    .full (q_full),
    .pop  (stat.cmd_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  assign cmd_valid = !q_empty;
  assign cmd       = cmd_t'(q_rdata);

endmodule

@@ hw/rtl/mvna_unit.sv @@
// ----------------------------------------------------------------------------
// Unit vector engine
// Brings a vector into a magnitude window, takes the integer square root of
// its squared length and divides each component down to Q2.14.
// ----------------------------------------------------------------------------
module mvna_unit (
  input  logic                clk,
  input  logic                rst,
  input  mvna_pkg::unit_req_t req,
  output mvna_pkg::unit_rsp_t rsp
);

  import mvna_pkg::*;

  localparam int LANES = 3;

  unit_state_t             state;
  unit_state_t             state_next;
  logic signed [VEC_W-1:0] w      [LANES];
  logic [VEC_W-1:0]        mag    [LANES];
  logic                    neg    [LANES];
  logic [4:0]              cnt;
  logic [2*MAG_W-1:0]      sq_prod;
  logic [VEC_W-1:0]        sum;
  logic [VEC_W-1:0]        sq_n;
  logic [ROOT_W-1:0]       root;
  logic [ROOT_W+1:0]       rem;
  logic [ROOT_W+3:0]       rem_sh;
  logic [ROOT_W+3:0]       trial;
  logic [ROOT_W-1:0]       dv_rem [LANES];
  logic [NRM_W-1:0]        dv_low [LANES];
  logic [ROOT_W:0]         dv_sh  [LANES];
  logic [NUM_W-1:0]        numer  [LANES];
  logic [NRM_W-1:0]        quo    [LANES];
  logic [MAG_W-1:0]        sq_op;
  logic                    over_hi;
  logic                    in_win;
  logic                    in_zero;

  always_comb begin
    over_hi = 1'b0;
    in_win  = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      mag[i]   = w[i][VEC_W-1] ? -w[i] : w[i];
      over_hi  = over_hi | (|mag[i][VEC_W-1:MAG_W]);
      in_win   = in_win | mag[i][MAG_W-1];
      numer[i] = NUM_W'({mag[i][MAG_W-1:0], {FRAC_W{1'b0}}}) + NUM_W'(root >> 1);
      dv_sh[i] = {dv_rem[i], dv_low[i][NRM_W-1]};
    end
    case (cnt[1:0])
      2'd0:    sq_op = mag[0][MAG_W-1:0];
      2'd1:    sq_op = mag[1][MAG_W-1:0];
      default: sq_op = mag[2][MAG_W-1:0];
    endcase
    rem_sh  = {rem, sq_n[VEC_W-1 -: 2]};
    trial   = {2'b00, root, 2'b01};
    in_zero = (req.vec.x == '0) && (req.vec.y == '0) && (req.vec.z == '0);
  end

  always_comb begin
    state_next = state;
    case (state)
      U_IDLE: begin
        if (req.start) begin
          state_next = in_zero ? U_FIN : U_NORM;
        end
      end
      U_NORM: begin
        if (!over_hi && in_win) begin
          state_next = U_SQ;
        end
      end
      U_SQ: begin
        if (cnt == 5'(SQ_STEPS - 1)) begin
          state_next = U_SQRT;
        end
      end
      U_SQRT: begin
        if (cnt == 5'(SQRT_STEPS - 1)) begin
          state_next = U_DSET;
        end
      end
      U_DSET: state_next = U_DIV;
      U_DIV: begin
        if (cnt == 5'(DIV_STEPS - 1)) begin
          state_next = U_FIN;
        end
      end
      U_FIN:   state_next = U_IDLE;
      default: state_next = U_IDLE;
    endcase
  end

  always_comb begin
    rsp.done  = (state == U_FIN);
    rsp.nrm.x = neg[0] ? -quo[0] : quo[0];
    rsp.nrm.y = neg[1] ? -quo[1] : quo[1];
    rsp.nrm.z = neg[2] ? -quo[2] : quo[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      case (state)
        U_IDLE: cnt <= '0;
        U_NORM: cnt <= '0;
        U_SQ, U_SQRT, U_DIV: begin
          if (state_next != state) begin
            cnt <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: cnt <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      U_IDLE: begin
        if (req.start) begin
          w[0]   <= req.vec.x;
          w[1]   <= req.vec.y;
          w[2]   <= req.vec.z;
          neg[0] <= req.vec.x[VEC_W-1];
          neg[1] <= req.vec.y[VEC_W-1];
          neg[2] <= req.vec.z[VEC_W-1];
          for (int i = 0; i < LANES; i++) begin
            quo[i] <= '0;
          end
        end
      end
      U_NORM: begin
        // halve (floor) while too large, double while too small
        for (int i = 0; i < LANES; i++) begin
          if (over_hi) begin
            w[i] <= w[i] >>> 1;
          end else if (!in_win) begin
            w[i] <= w[i] <<< 1;
          end
        end
      end
      U_SQ: begin
        sq_prod <= sq_op * sq_op;
        if (cnt == '0) begin
          sum <= '0;
        end else begin
          sum <= sum + VEC_W'(sq_prod);
        end
        if (cnt == 5'(SQ_STEPS - 1)) begin
          sq_n <= sum + VEC_W'(sq_prod);
          root <= '0;
          rem  <= '0;
        end
      end
      U_SQRT: begin
        if (rem_sh >= trial) begin
          rem  <= (ROOT_W+2)'(rem_sh - trial);
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[ROOT_W+1:0];
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        sq_n <= sq_n << 2;
      end
      U_DSET: begin
        for (int i = 0; i < LANES; i++) begin
          dv_rem[i] <= ROOT_W'(numer[i][NUM_W-1:NRM_W]);
          dv_low[i] <= numer[i][NRM_W-1:0];
          quo[i]    <= '0;
        end
      end
      U_DIV: begin
        for (int i = 0; i < LANES; i++) begin
          if (dv_sh[i] >= {1'b0, root}) begin
            dv_rem[i] <= ROOT_W'(dv_sh[i] - {1'b0, root});
            quo[i]    <= {quo[i][NRM_W-2:0], 1'b1};
          end else begin
            dv_rem[i] <= dv_sh[i][ROOT_W-1:0];
            quo[i]    <= {quo[i][NRM_W-2:0], 1'b0};
          end
          dv_low[i] <= dv_low[i] << 1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hw/rtl/mvna_back.sv @@
// ----------------------------------------------------------------------------
// Back end
// Sequences commands against the position and accumulator stores: vertex
// writes, face normal cross products, saturating adds and normal reads.
// ----------------------------------------------------------------------------
module mvna_back #(
  parameter int VERTEX_DEPTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  input  mvna_pkg::cmd_t       cmd,
  output mvna_pkg::back_stat_t stat,
  input  logic                 res_full,
  output logic                 res_push,
  output mvna_pkg::result_t    res,
  output mvna_pkg::unit_req_t  ureq,
  input  mvna_pkg::unit_rsp_t  ursp
);

  import mvna_pkg::*;

  localparam int AW = $clog2(VERTEX_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(VERTEX_DEPTH - 1);
  localparam logic signed [POS_W:0] EDGE_LIM = 33'sd1073741824;

  function automatic logic is_big(logic signed [POS_W:0] c);
    return (c >= EDGE_LIM) || (c <= -EDGE_LIM);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(logic signed [ACC_W-1:0] a,
                                                      logic signed [NRM_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

  back_state_t              state;
  back_state_t              state_next;
  logic [AW-1:0]            clr_addr;
  cmd_t                     cur;
  pos_t                     pa;
  pos_t                     pb;
  pos_t                     pos_rd;
  acc_t                     acc_rd;
  acc_t                     acc_new;
  logic signed [POS_W:0]    e1r [3];
  logic signed [POS_W:0]    e2r [3];
  logic signed [POS_W:0]    e1t [3];
  logic signed [POS_W:0]    e2t [3];
  logic signed [EDGE_W-1:0] e1s [3];
  logic signed [EDGE_W-1:0] e2s [3];
  logic signed [EDGE_W-1:0] ma;
  logic signed [EDGE_W-1:0] mb;
  logic signed [VEC_W-1:0]  prod;
  logic signed [VEC_W-1:0]  cr  [3];
  logic [2:0]               mul_cnt;
  logic [1:0]               corner;
  logic [IDX_W-1:0]         corner_idx;

  logic                     pos_we;
  logic [AW-1:0]            pos_waddr;
  logic                     pos_re;
  logic [AW-1:0]            pos_raddr;
  logic [$bits(pos_t)-1:0]  pos_rdata;
  logic                     acc_we;
  logic [AW-1:0]            acc_waddr;
  logic [$bits(acc_t)-1:0]  acc_wdata;
  logic                     acc_re;
  logic [AW-1:0]            acc_raddr;
  logic [$bits(acc_t)-1:0]  acc_rdata;

  assign pos_rd = pos_t'(pos_rdata);
  assign acc_rd = acc_t'(acc_rdata);

  always_comb begin
    case (corner)
      2'd0:    corner_idx = cur.ca;
      2'd1:    corner_idx = cur.cb;
      default: corner_idx = cur.cc;
    endcase
    acc_new.x = sat_add(acc_rd.x, ursp.nrm.x);
    acc_new.y = sat_add(acc_rd.y, ursp.nrm.y);
    acc_new.z = sat_add(acc_rd.z, ursp.nrm.z);
  end

  // edge range reduction: halve each edge until its components are below 2^30
  always_comb begin
    logic big1;
    logic big2;
    for (int i = 0; i < 3; i++) begin
      e1t[i] = e1r[i];
      e2t[i] = e2r[i];
    end
    for (int s = 0; s < SHRINK_STEPS; s++) begin
      big1 = is_big(e1t[0]) || is_big(e1t[1]) || is_big(e1t[2]);
      big2 = is_big(e2t[0]) || is_big(e2t[1]) || is_big(e2t[2]);
      for (int i = 0; i < 3; i++) begin
        if (big1) begin
          e1t[i] = e1t[i] >>> 1;
        end
        if (big2) begin
          e2t[i] = e2t[i] >>> 1;
        end
      end
    end
  end

  always_comb begin
    case (mul_cnt)
      3'd0: begin ma = e1s[1]; mb = e2s[2]; end
      3'd1: begin ma = e1s[2]; mb = e2s[1]; end
      3'd2: begin ma = e1s[2]; mb = e2s[0]; end
      3'd3: begin ma = e1s[0]; mb = e2s[2]; end
      3'd4: begin ma = e1s[0]; mb = e2s[1]; end
      default: begin ma = e1s[1]; mb = e2s[0]; end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      B_CLEAR: begin
        if (clr_addr == LAST_ADDR) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            CMD_TRIANGLE: state_next = B_PA;
            CMD_READ:     state_next = B_RD;
            default:      state_next = B_IDLE;
          endcase
        end
      end
      B_PA:   state_next = B_PB;
      B_PB:   state_next = B_PC;
      B_PC:   state_next = B_EDGE;
      B_EDGE: state_next = B_MUL;
      B_MUL: begin
        if (mul_cnt == 3'(MUL_STEPS)) begin
          state_next = B_USTART;
        end
      end
      B_USTART: state_next = B_UNIT_TRI;
      B_UNIT_TRI: begin
        if (ursp.done) begin
          state_next = B_ACC_RD;
        end
      end
      B_ACC_RD: state_next = B_ACC_WR;
      B_ACC_WR: begin
        if (corner == 2'(CORNERS - 1)) begin
          state_next = B_IDLE;
        end else begin
          state_next = B_ACC_RD;
        end
      end
      B_RD: state_next = B_UNIT_RD;
      B_UNIT_RD: begin
        if (ursp.done) begin
          state_next = B_OUT;
        end
      end
      B_OUT: begin
        if (!res_full) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    stat.cmd_pop  = 1'b0;
    stat.clearing = 1'b0;
    pos_we        = 1'b0;
    pos_waddr     = AW'(cmd.idx);
    pos_re        = 1'b0;
    pos_raddr     = AW'(cmd.ca);
    acc_we        = 1'b0;
    acc_waddr     = AW'(cmd.idx);
    acc_wdata     = '0;
    acc_re        = 1'b0;
    acc_raddr     = AW'(cmd.idx);
    res_push      = 1'b0;
    res.idx       = cur.idx;
    res.nrm       = ursp.nrm;
    ureq.start    = 1'b0;
    ureq.vec.x    = cr[0];
    ureq.vec.y    = cr[1];
    ureq.vec.z    = cr[2];
    case (state)
      B_CLEAR: begin
        stat.clearing = 1'b1;
        acc_we        = 1'b1;
        acc_waddr     = clr_addr;
      end
      B_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            CMD_WRITE: begin
              pos_we       = 1'b1;
              acc_we       = 1'b1;
              stat.cmd_pop = 1'b1;
            end
            CMD_TRIANGLE: begin
              pos_re       = 1'b1;
              stat.cmd_pop = 1'b1;
            end
            CMD_READ: begin
              acc_re       = 1'b1;
              stat.cmd_pop = 1'b1;
            end
            default: begin
              if (!res_full) begin
                res_push     = 1'b1;
                res.idx      = cmd.idx;
                res.nrm      = '0;
                stat.cmd_pop = 1'b1;
              end
            end
          endcase
        end
      end
      B_PA: begin
        pos_re    = 1'b1;
        pos_raddr = AW'(cur.cb);
      end
      B_PB: begin
        pos_re    = 1'b1;
        pos_raddr = AW'(cur.cc);
      end
      B_USTART: ureq.start = 1'b1;
      B_ACC_RD: begin
        acc_re    = 1'b1;
        acc_raddr = AW'(corner_idx);
      end
      B_ACC_WR: begin
        acc_we    = 1'b1;
        acc_waddr = AW'(corner_idx);
        acc_wdata = acc_new;
      end
      B_RD: begin
        ureq.start = 1'b1;
        ureq.vec.x = VEC_W'(acc_rd.x);
        ureq.vec.y = VEC_W'(acc_rd.y);
        ureq.vec.z = VEC_W'(acc_rd.z);
      end
      B_OUT: res_push = !res_full;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
      mul_cnt  <= '0;
      corner   <= '0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == B_EDGE) begin
        mul_cnt <= '0;
      end else if (state == B_MUL) begin
        mul_cnt <= mul_cnt + 1'b1;
      end
      if (state == B_IDLE) begin
        corner <= '0;
      end else if (state == B_ACC_WR) begin
        corner <= corner + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stat.cmd_pop) begin
      cur <= cmd;
    end
    case (state)
      B_PA: pa <= pos_rd;
      B_PB: pb <= pos_rd;
      B_PC: begin
        e1r[0] <= (POS_W+1)'(pos_rd.x) - (POS_W+1)'(pa.x);
        e1r[1] <= (POS_W+1)'(pos_rd.y) - (POS_W+1)'(pa.y);
        e1r[2] <= (POS_W+1)'(pos_rd.z) - (POS_W+1)'(pa.z);
        e2r[0] <= (POS_W+1)'(pb.x) - (POS_W+1)'(pa.x);
        e2r[1] <= (POS_W+1)'(pb.y) - (POS_W+1)'(pa.y);
        e2r[2] <= (POS_W+1)'(pb.z) - (POS_W+1)'(pa.z);
      end
      B_EDGE: begin
        for (int i = 0; i < 3; i++) begin
          e1s[i] <= e1t[i][EDGE_W-1:0];
          e2s[i] <= e2t[i][EDGE_W-1:0];
        end
      end
      B_MUL: begin
        prod <= ma * mb;
        // each cross component is one product minus the next
        case (mul_cnt)
          3'd1:    cr[0] <= prod;
          3'd2:    cr[0] <= cr[0] - prod;
          3'd3:    cr[1] <= prod;
          3'd4:    cr[1] <= cr[1] - prod;
          3'd5:    cr[2] <= prod;
          3'd6:    cr[2] <= cr[2] - prod;
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  mvna_ram #(
    .WIDTH($bits(pos_t)),
    .DEPTH(VERTEX_DEPTH)
  ) u_pos_ram (
    .clk  (clk),
    .we   (pos_we),
    .waddr(pos_waddr),
    .wdata(cmd.pos),
    .re   (pos_re),
    .raddr(pos_raddr),
    .rdata(pos_rdata)
  );

  mvna_ram #(
    .WIDTH($bits(acc_t)),
    .DEPTH(VERTEX_DEPTH)
  ) u_acc_ram (
    .clk  (clk),
    .we   (acc_we),
    .waddr(acc_waddr),
    .wdata(acc_wdata),
    .re   (acc_re),
    .raddr(acc_raddr),
    .rdata(acc_rdata)
  );

endmodule

@@ hw/rtl/mesh_vertex_normal_accumulator.sv @@
// Triangles and reads each use the unit vector engine, whose steps are window, square, root,
//   divide and done; vertex writes do not use the engine.
// Throughput: one command at a time in the back end, set by the bit-serial root and divide
//   loops of the unit vector engine; writes sustain one per cycle while the back end is idle.
// Reset: rst clears control, then every address of the accumulator store is swept to zero.
// ----------------------------------------------------------------------------
// Mesh vertex normal accumulator
// Vertex position store with per-vertex face normal accumulation and unit
// normal readback.
// ----------------------------------------------------------------------------
module mesh_vertex_normal_accumulator #(
  parameter int VERTEX_DEPTH = mvna_pkg::DEF_VERTEX_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [1:0]                        action,
  input  logic [mvna_pkg::IDX_W-1:0]        vertex_index,
  input  logic signed [mvna_pkg::POS_W-1:0] position_x,
  input  logic signed [mvna_pkg::POS_W-1:0] position_y,
  input  logic signed [mvna_pkg::POS_W-1:0] position_z,
  input  logic [mvna_pkg::IDX_W-1:0]        corner_a,
  input  logic [mvna_pkg::IDX_W-1:0]        corner_b,
  input  logic [mvna_pkg::IDX_W-1:0]        corner_c,
  output logic                              empty,
  input  logic                              pop,
  output logic [mvna_pkg::IDX_W-1:0]        out_index,
  output logic signed [mvna_pkg::NRM_W-1:0] normal_x,
  output logic signed [mvna_pkg::NRM_W-1:0] normal_y,
  output logic signed [mvna_pkg::NRM_W-1:0] normal_z
);

  import mvna_pkg::*;

  back_stat_t          stat;
  logic                cmd_valid;
  cmd_t                cmd;
  logic                res_full;
  logic                res_push;
  result_t             res;
  result_t             res_head;
  logic [RESULT_W-1:0] res_rdata;
  unit_req_t           ureq;
  unit_rsp_t           ursp;

  mvna_front #(
    .VERTEX_DEPTH(VERTEX_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .action      (action),
    .vertex_index(vertex_index),
    .position_x  (position_x),
    .position_y  (position_y),
    .position_z  (position_z),
    .corner_a    (corner_a),
    .corner_b    (corner_b),
    .corner_c    (corner_c),
    .stat        (stat),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd)
  );

  mvna_back #(
    .VERTEX_DEPTH(VERTEX_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .stat     (stat),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res),
    .ureq     (ureq),
    .ursp     (ursp)
  );

  mvna_unit u_unit (
    .clk(clk),
    .rst(rst),
    .req(ureq),
    .rsp(ursp)
  );

  mvna_queue #(
    .WIDTH(RESULT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res),
    .full (res_full),
    .pop  (pop),
    .rdata(res_rdata),
    .empty(empty)
  );

  assign res_head  = result_t'(res_rdata);
  assign out_index = res_head.idx;
  assign normal_x  = res_head.nrm.x;
  assign normal_y  = res_head.nrm.y;
  assign normal_z  = res_head.nrm.z;

endmodule

@@ hw/rtl/mvna_checker.sv @@
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level's ports for reset, stall and range behavior.
// ----------------------------------------------------------------------------
module mvna_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              full,
  input logic                              empty,
  input logic                              pop,
  input logic [mvna_pkg::IDX_W-1:0]        out_index,
  input logic signed [mvna_pkg::NRM_W-1:0] normal_x,
  input logic signed [mvna_pkg::NRM_W-1:0] normal_y,
  input logic signed [mvna_pkg::NRM_W-1:0] normal_z
);

  import mvna_pkg::*;

  localparam logic signed [NRM_W-1:0] ONE = 16'sd16384;

  // no result survives reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // the store sweep holds off input right after reset
  a_reset_full: assert property (@(posedge clk) rst |=> full)
    else $error("input accepted during store sweep");

  // a waiting word holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_index) && $stable(normal_x)
                          && $stable(normal_y) && $stable(normal_z)))
    else $error("waiting result word changed");

  // unit normal components stay within one
  a_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (normal_x <= ONE && normal_x >= -ONE && normal_y <= ONE
                && normal_y >= -ONE && normal_z <= ONE && normal_z >= -ONE))
    else $error("normal component out of range");

endmodule

bind mesh_vertex_normal_accumulator mvna_checker u_mvna_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh vertex normal accumulator testbench
// Drives vertex writes, triangles and normal reads through the push/full
// port, predicts each returned normal word with an independent fixed-point
// model of the vertex and accumulator stores, and checks it at pop time.
// ----------------------------------------------------------------------------
module tb_top;
  import mvna_pkg::*;

  localparam int IDLE_PCT   = 22;
  localparam int STALL_MAX  = 20000;
  localparam int ACC_HI     = 8388607;
  localparam int ACC_LO     = -8388608;
  localparam int UNIT_ONE   = 16384;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic signed [NRM_W-1:0] nx, ny, nz;
  } normal_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic [1:0] action = '0;
  logic [IDX_W-1:0] vertex_index = '0, corner_a = '0, corner_b = '0, corner_c = '0;
  logic signed [POS_W-1:0] position_x = '0, position_y = '0, position_z = '0;
  logic [IDX_W-1:0] out_index;
  logic signed [NRM_W-1:0] normal_x, normal_y, normal_z;

  int vert_pos [DEF_VERTEX_DEPTH][3];
  int vert_sum [DEF_VERTEX_DEPTH][3];
  bit vert_set [DEF_VERTEX_DEPTH];
  logic [IDX_W-1:0] set_list[$];
  normal_word_t normal_q[$];

  int errors = 0;
  int n_items = 0, n_normals = 0, stall_cnt = 0;
  bit quiet = 1'b0;

  mesh_vertex_normal_accumulator i_dut (
    .clk, .rst, .push, .full, .action, .vertex_index,
    .position_x, .position_y, .position_z,
    .corner_a, .corner_b, .corner_c,
    .empty, .pop, .out_index, .normal_x, .normal_y, .normal_z
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---- predictor --------------------------------------------------------
  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint mag3(longint x, longint y, longint z);
    longint m;
    m = (x < 0) ? -x : x;
    if (((y < 0) ? -y : y) > m) m = (y < 0) ? -y : y;
    if (((z < 0) ? -z : z) > m) m = (z < 0) ? -z : z;
    return m;
  endfunction

  function automatic void unit_dir(input longint x, y, z, output longint ox, oy, oz);
    longint w[3];
    longint unsigned s, len, a;
    longint q;
    w = '{x, y, z};
    if (mag3(x, y, z) == 0) begin
      ox = 0; oy = 0; oz = 0;
      return;
    end
    while (mag3(w[0], w[1], w[2]) >= (64'sd1 <<< 30))
      foreach (w[i]) w[i] = w[i] >>> 1;
    while (mag3(w[0], w[1], w[2]) < (64'sd1 <<< 29))
      foreach (w[i]) w[i] = w[i] * 2;
    s = 0;
    foreach (w[i]) s += longint'(w[i] * w[i]);
    len = int_root(s);
    foreach (w[i]) begin
      a = (w[i] < 0) ? -w[i] : w[i];
      q = (a * UNIT_ONE + len / 2) / len;
      w[i] = (w[i] < 0) ? -q : q;
    end
    ox = w[0]; oy = w[1]; oz = w[2];
  endfunction

  function automatic void add_face(int v, longint nx, ny, nz);
    longint n[3];
    longint t;
    n = '{nx, ny, nz};
    for (int i = 0; i < 3; i++) begin
      t = longint'(vert_sum[v][i]) + n[i];
      if (t > ACC_HI) t = ACC_HI;
      if (t < ACC_LO) t = ACC_LO;
      vert_sum[v][i] = int'(t);
    end
  endfunction

  task automatic predict(action_t a, logic [IDX_W-1:0] vi, int px, py, pz,
                         logic [IDX_W-1:0] ca, cb, cc);
    longint e1[3], e2[3], cx, cy, cz, nx, ny, nz;
    normal_word_t w;
    case (a)
      ACT_WRITE: begin
        vert_pos[vi] = '{px, py, pz};
        vert_sum[vi] = '{0, 0, 0};
        if (!vert_set[vi]) set_list = {set_list, vi};
        vert_set[vi] = 1'b1;
      end
      ACT_TRIANGLE: begin
        for (int i = 0; i < 3; i++) begin
          e1[i] = longint'(vert_pos[cc][i]) - vert_pos[ca][i];
          e2[i] = longint'(vert_pos[cb][i]) - vert_pos[ca][i];
        end
        while (mag3(e1[0], e1[1], e1[2]) >= (64'sd1 <<< 30))
          foreach (e1[i]) e1[i] = e1[i] >>> 1;
        while (mag3(e2[0], e2[1], e2[2]) >= (64'sd1 <<< 30))
          foreach (e2[i]) e2[i] = e2[i] >>> 1;
        cx = e1[1] * e2[2] - e1[2] * e2[1];
        cy = e1[2] * e2[0] - e1[0] * e2[2];
        cz = e1[0] * e2[1] - e1[1] * e2[0];
        unit_dir(cx, cy, cz, nx, ny, nz);
        add_face(ca, nx, ny, nz);
        add_face(cb, nx, ny, nz);
        add_face(cc, nx, ny, nz);
      end
      ACT_READ: begin
        unit_dir(vert_sum[vi][0], vert_sum[vi][1], vert_sum[vi][2], nx, ny, nz);
        w.idx = vi;
        w.nx = nx[NRM_W-1:0];
        w.ny = ny[NRM_W-1:0];
        w.nz = nz[NRM_W-1:0];
        normal_q = {normal_q, w};
      end
      default: ;
    endcase
  endtask

  // ---- driving ----------------------------------------------------------
  task automatic send(action_t a, logic [IDX_W-1:0] vi, int px, py, pz,
                      logic [IDX_W-1:0] ca, cb, cc);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      push = 1'b0;
      @(negedge clk);
    end
    action = a;
    vertex_index = vi;
    position_x = px; position_y = py; position_z = pz;
    corner_a = ca; corner_b = cb; corner_c = cc;
    push = 1'b1;
    do @(posedge clk); while (full);
    predict(a, vi, px, py, pz, ca, cb, cc);
    n_items++;
    @(negedge clk);
    push = 1'b0;
  endtask

  task automatic put_vertex(logic [IDX_W-1:0] vi, int px, py, pz);
    send(ACT_WRITE, vi, px, py, pz, IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
  endtask

  task automatic put_face(logic [IDX_W-1:0] ca, cb, cc);
    send(ACT_TRIANGLE, IDX_W'($urandom), $urandom, $urandom, $urandom, ca, cb, cc);
  endtask

  task automatic get_normal(logic [IDX_W-1:0] vi);
    send(ACT_READ, vi, $urandom, $urandom, $urandom,
         IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
  endtask

  always @(negedge clk) pop = quiet || ($urandom_range(99) >= IDLE_PCT);

  // ---- checking ---------------------------------------------------------
  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  always @(posedge clk) begin
    normal_word_t w;
    if (!rst && pop && !empty) begin
      n_normals++;
      if (normal_q.size() == 0) begin
        report("unexpected word, index", out_index, -1);
      end else begin
        w = normal_q.pop_front();
        if (out_index !== w.idx) report("out_index", out_index, w.idx);
        if (normal_x !== w.nx) report("normal_x", normal_x, w.nx);
        if (normal_y !== w.ny) report("normal_y", normal_y, w.ny);
        if (normal_z !== w.nz) report("normal_z", normal_z, w.nz);
      end
    end
  end

  // watchdog: any accepted word on either side restarts the count
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_MAX) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // ---- tests ------------------------------------------------------------
  task automatic test_extremes();
    put_vertex(0, 32'h7fff_ffff, 32'h8000_0000, 0);
    put_vertex(12'hfff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    put_vertex(12'haaa, 0, 32'h8000_0000, 32'h7fff_ffff);
    put_vertex(12'h555, 1, 0, 0);
    put_vertex(12'h001, 0, 1, 0);
    put_vertex(12'h002, 0, 0, 1);
    put_face(0, 12'hfff, 12'haaa);
    put_face(12'h555, 12'h001, 12'h002);  // tiny edges: scale up into window
    put_face(12'h002, 12'h001, 12'h555);  // reversed winding
    get_normal(0);
    get_normal(12'hfff);
    get_normal(12'haaa);
    get_normal(12'h555);
  endtask

  task automatic test_special();
    put_vertex(3, 0, 0, 0);
    put_vertex(4, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    put_vertex(5, 32'h0002_0000, 32'h0002_0000, 32'h0002_0000);
    put_face(3, 4, 5);                    // collinear: zero face normal
    get_normal(3);
    get_normal(100);                      // untouched accumulator
    put_face(0, 0, 12'hfff);              // repeated corner
    send(ACT_NONE, IDX_W'($urandom), $urandom, $urandom, $urandom,
         IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
    put_vertex(0, 5, 6, 7);               // rewrite clears the sum
    get_normal(0);
    get_normal(0);
  endtask

  task automatic test_saturation();
    put_vertex(10, 0, 0, 0);
    put_vertex(11, 0, 32'h0001_0000, 0);
    put_vertex(12, 0, 0, 32'h0001_0000);
    for (int i = 0; i < 520; i++) begin
      put_face(10, 11, 12);
      if (i % 64 == 0) get_normal(11);
    end
    for (int i = 0; i < 30; i++) put_face(10, 12, 11);  // back off the rail
    get_normal(10);
    get_normal(12);
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    return ($urandom_range(99) < 85) ? IDX_W'($urandom_range(47)) : IDX_W'($urandom);
  endfunction

  task automatic test_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      quiet = (i >= count / 3 && i < count / 2);
      r = $urandom_range(99);
      if (r < 25 || set_list.size() < 3) begin
        if ($urandom_range(1))
          put_vertex(pick_index(), $urandom, $urandom, $urandom);
        else
          put_vertex(pick_index(), $signed($urandom_range(65535)) - 32768,
                     $signed($urandom_range(65535)) - 32768,
                     $signed($urandom_range(65535)) - 32768);
      end else if (r < 70) begin
        put_face(set_list[$urandom_range(set_list.size() - 1)],
                 set_list[$urandom_range(set_list.size() - 1)],
                 set_list[$urandom_range(set_list.size() - 1)]);
      end else if (r < 97) begin
        get_normal(($urandom_range(3) != 0) ? set_list[$urandom_range(set_list.size() - 1)]
                                            : pick_index());
      end else begin
        send(ACT_NONE, IDX_W'($urandom), $urandom, $urandom, $urandom,
             IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_special();
    test_saturation();
    test_random(560);
    while (normal_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (normal_q.size() != 0) report("words left over", normal_q.size(), 0);
    $display("covered %0d input words and %0d normal reads", n_items, n_normals);
    $display("incl. extreme positions, degenerate faces, repeats, saturation");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/mvna_pkg.sv
hw/rtl/mvna_ram.sv
hw/rtl/mvna_queue.sv
hw/rtl/mvna_front.sv
hw/rtl/mvna_unit.sv
hw/rtl/mvna_back.sv
hw/rtl/mesh_vertex_normal_accumulator.sv
hw/rtl/mvna_checker.sv
tb/sv/tb_top.sv
